/* sv/alsched_pkg.sv */
// ----------------------------------------------------------------------------
// alsched_pkg
// Types and constants shared by the all-gather step schedule modules.
// ----------------------------------------------------------------------------
package alsched_pkg;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 48;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_RANK_COUNT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MY_INDEX   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_COUNT = 2'd2;

  // Most slice results that one step request may produce.
  localparam logic [6:0] RESULT_CAP = 7'd64;

  // Request into the shared remainder unit.
  typedef struct packed {
    logic       start;
    logic [7:0] dividend;
    logic [7:0] divisor;
  } rem_req_t;

  // Status back from the shared remainder unit.
  typedef struct packed {
    logic       busy;
    logic       done;
    logic [7:0] rem;
  } rem_rsp_t;

  // Result payload, last field in the lowest bits.
  typedef struct packed {
    logic [6:0] pad;
    logic [6:0] rx_slice;
    logic [6:0] tx_slice;
    logic [5:0] slice_pos;
    logic [6:0] slice_count;
    logic [6:0] to_index;
    logic [6:0] from_index;
  } out_data_t;

endpackage

/* sv/alsched_rem.sv */
// ----------------------------------------------------------------------------
// alsched_rem
// Shared restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module alsched_rem (
  input  logic                 clk,
  input  logic                 rst_n,
  input  alsched_pkg::rem_req_t req,
  output alsched_pkg::rem_rsp_t rsp
);

  logic       busy_r;
  logic       done_r;
  logic [2:0] cnt_r;
  logic [7:0] rem_r;
  logic [7:0] num_r;
  logic [7:0] div_r;
  logic [8:0] trial;
  logic [7:0] rem_nxt;

  // Shift in the next dividend bit and subtract the divisor when it fits.
  always_comb begin
    trial = {rem_r, num_r[7]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = 8'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = trial[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 3'd7;
        rem_r  <= 8'd0;
        num_r  <= req.dividend;
        div_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        num_r <= {num_r[6:0], 1'b0};
        cnt_r <= cnt_r - 3'd1;
        if (cnt_r == 3'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

/* sv/allgather_step_schedule.sv */
// ----------------------------------------------------------------------------
// allgather_step_schedule
// Transfer plan of one all-gather step: peers and per-slice indices.
// ----------------------------------------------------------------------------
// Usage: write rank_count, my_index and step_count on the cfg_ port while
// the block is idle. Each request on the in_ stream carries a step number
// and produces a run of results on the out_ stream, one per slice, with
// out_tlast on the final one. A step at or beyond step_count gives a single
// result with out_tuser (bad_step) set and all data fields zero.
// Sequence: a request runs three remainder passes on one shared shift-subtract
// unit (my_index, delta and twice delta, each modulo the clamped rank count),
// then a setup state, then one result per cycle while the receiver takes
// them. A bad step gives its single result without remainder passes.
// in_tready is high only between requests.
// The output register holds a result until it is taken; a stalled receiver
// stops the slice walk without loss. A new request may be accepted while
// the final result of the previous one still waits.
// Reset (synchronous, active low) loads rank_count 2, my_index 0,
// step_count 1 and empties the output.
module allgather_step_schedule #(
  parameter int MAX_RANKS = 128
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: step[2:0], zero fill [7:3]
  input  logic [alsched_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // out_tdata: from_index[6:0], to_index[13:7], slice_count[20:14],
  // slice_pos[26:21], tx_slice[33:27], rx_slice[40:34], zero fill [47:41]
  output logic [alsched_pkg::OUT_DATA_W-1:0]   out_tdata,
  // out_tuser: bad_step[0]
  output logic                                 out_tuser,
  output logic                                 out_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_we,
  input  logic [alsched_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [alsched_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam logic [7:0] MAX_R = 8'(MAX_RANKS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_IDX,
    S_DM,
    S_D2M,
    S_SETUP,
    S_EMIT,
    S_BAD
  } state_t;

  state_t                state_r;
  logic [7:0]            rank_count_r;
  logic [6:0]            my_index_r;
  logic [2:0]            step_count_r;

  alsched_pkg::rem_req_t rem_req;
  alsched_pkg::rem_rsp_t rem_rsp;
  logic                  start_r;
  logic [7:0]            dividend_r;

  logic [2:0]            shamt_r;
  logic [7:0]            r_r;
  logic [7:0]            delta_r;
  logic [6:0]            idx_r;
  logic [6:0]            dm_r;
  logic [6:0]            d2m_r;
  logic [6:0]            from_r;
  logic [6:0]            to_r;
  logic [6:0]            n_r;
  logic [5:0]            pos_r;
  logic [6:0]            tx_r;
  logic [6:0]            rx_r;

  alsched_pkg::out_data_t out_data_r;
  logic                  out_valid_r;
  logic                  out_last_r;
  logic                  out_bad_r;

  logic                  in_acc;
  logic                  out_free;
  logic [2:0]            in_step;
  logic                  in_bad;
  logic [7:0]            r_clamp;
  logic [8:0]            span;
  logic [8:0]            n_full;
  logic [6:0]            n_calc;
  logic                  emit_last;

  // (a + r - b) mod r for a, b below r.
  function automatic logic [6:0] mod_sub(input logic [6:0] a, input logic [6:0] b,
                                         input logic [7:0] r);
    logic [8:0] t;
    t = {2'b00, a} + {1'b0, r} - {2'b00, b};
    if (t >= {1'b0, r}) begin
      t = t - {1'b0, r};
    end
    return t[6:0];
  endfunction

  // (a + b) mod r for a, b below r.
  function automatic logic [6:0] mod_add(input logic [6:0] a, input logic [6:0] b,
                                         input logic [7:0] r);
    logic [8:0] t;
    t = {2'b00, a} + {2'b00, b};
    if (t >= {1'b0, r}) begin
      t = t - {1'b0, r};
    end
    return t[6:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_count_r <= 8'd2;
      my_index_r   <= 7'd0;
      step_count_r <= 3'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        alsched_pkg::REG_RANK_COUNT: rank_count_r <= cfg_wdata;
        alsched_pkg::REG_MY_INDEX:   my_index_r   <= cfg_wdata[6:0];
        alsched_pkg::REG_STEP_COUNT: step_count_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign in_step   = in_tdata[2:0];
  assign in_bad    = (in_step >= step_count_r);

  always_comb begin
    r_clamp = rank_count_r;
    if (rank_count_r < 8'd2) begin
      r_clamp = 8'd2;
    end else if (rank_count_r > MAX_R) begin
      r_clamp = MAX_R;
    end
  end

  // Slice count (R - 1 + delta) / (2 * delta), a shift since delta is 2^shamt.
  always_comb begin
    span   = {1'b0, r_r} - 9'd1 + {1'b0, delta_r};
    n_full = span >> ({1'b0, shamt_r} + 4'd1);
    if (n_full > {2'b00, alsched_pkg::RESULT_CAP}) begin
      n_calc = alsched_pkg::RESULT_CAP;
    end else begin
      n_calc = n_full[6:0];
    end
  end

  assign emit_last = (n_r == 7'd0) || ({1'b0, pos_r} + 7'd1 == n_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            shamt_r <= step_count_r - 3'd1 - in_step;
            delta_r <= 8'd1 << (step_count_r - 3'd1 - in_step);
            r_r     <= r_clamp;
            if (in_bad) begin
              state_r <= S_BAD;
            end else begin
              start_r    <= 1'b1;
              dividend_r <= {1'b0, my_index_r};
              state_r    <= S_IDX;
            end
          end
        end
        S_IDX: begin
          if (rem_rsp.done) begin
            idx_r      <= rem_rsp.rem[6:0];
            start_r    <= 1'b1;
            dividend_r <= delta_r;
            state_r    <= S_DM;
          end
        end
        S_DM: begin
          if (rem_rsp.done) begin
            dm_r       <= rem_rsp.rem[6:0];
            start_r    <= 1'b1;
            dividend_r <= {delta_r[6:0], 1'b0};
            state_r    <= S_D2M;
          end
        end
        S_D2M: begin
          if (rem_rsp.done) begin
            d2m_r   <= rem_rsp.rem[6:0];
            state_r <= S_SETUP;
          end
        end
        S_SETUP: begin
          from_r  <= mod_sub(idx_r, dm_r, r_r);
          to_r    <= mod_add(idx_r, dm_r, r_r);
          tx_r    <= idx_r;
          rx_r    <= mod_sub(idx_r, dm_r, r_r);
          n_r     <= n_calc;
          pos_r   <= 6'd0;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r           <= 1'b1;
            out_last_r            <= emit_last;
            out_bad_r             <= 1'b0;
            out_data_r.pad        <= 7'd0;
            out_data_r.from_index <= from_r;
            out_data_r.to_index   <= to_r;
            out_data_r.slice_count <= n_r;
            if (n_r == 7'd0) begin
              out_data_r.slice_pos <= 6'd0;
              out_data_r.tx_slice  <= 7'd0;
              out_data_r.rx_slice  <= 7'd0;
            end else begin
              out_data_r.slice_pos <= pos_r;
              out_data_r.tx_slice  <= tx_r;
              out_data_r.rx_slice  <= rx_r;
            end
            tx_r  <= mod_sub(tx_r, d2m_r, r_r);
            rx_r  <= mod_sub(rx_r, d2m_r, r_r);
            pos_r <= pos_r + 6'd1;
            if (emit_last) begin
              state_r <= S_IDLE;
            end
          end
        end
        S_BAD: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_last_r  <= 1'b1;
            out_bad_r   <= 1'b1;
            out_data_r  <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign rem_req.start    = start_r;
  assign rem_req.dividend = dividend_r;
  assign rem_req.divisor  = r_r;

  alsched_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  assign out_tdata  = out_data_r;
  assign out_tuser  = out_bad_r;
  assign out_tlast  = out_last_r;
  assign out_tvalid = out_valid_r;

`ifndef NO_ASSERTIONS
  // A bad step is always a run of one.
  a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("bad_step result without last");

  // The block takes one request at a time.
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while busy");

  // An empty step gives one result with zeroed slice fields.
  a_empty_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser && (out_tdata[20:14] == 7'd0)
      |-> out_tlast && (out_tdata[33:21] == 13'd0) && (out_tdata[40:34] == 7'd0))
    else $error("empty step result malformed");

  // Slice position stays inside the slice list.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser && (out_tdata[20:14] != 7'd0)
      |-> ({1'b0, out_tdata[26:21]} < out_tdata[20:14]))
    else $error("slice_pos beyond slice_count");

  // The remainder unit only finishes while the sequencer waits on it.
  a_rem_done: assert property (@(posedge clk) disable iff (!rst_n)
    rem_rsp.done |-> (state_r == S_IDX) || (state_r == S_DM) || (state_r == S_D2M))
    else $error("remainder done outside a remainder pass");

  // A remainder pass is only started on an idle unit.
  a_rem_start: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> !rem_rsp.busy)
    else $error("remainder pass started while busy");
`endif

endmodule

/* test/allgather_step_schedule_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// allgather_step_schedule_tb
// Self-checking bench for the all-gather step schedule block.
// ----------------------------------------------------------------------------
// Step requests go in on the in_ stream. A scoreboard computes the peers and
// the slice walk of every accepted request and compares each result on the
// out_ stream, field by field and in order. Both streams idle and stall at
// random. Registers are rewritten between phases, once the block has drained.
// The directed phase covers the field extremes, clamping of the rank count,
// reduction of my_index, bad steps and steps whose distance reaches the rank
// count. Random phases follow with mostly valid steps.
// ----------------------------------------------------------------------------

class slice_plan_board;

  typedef struct packed {
    alsched_pkg::out_data_t data;
    logic                   last;
    logic                   bad;
  } slice_rec_t;

  logic [7:0] ranks;
  logic [6:0] my_pos;
  logic [2:0] step_total;
  slice_rec_t plan_q[$];
  int unsigned errors;

  function new();
    ranks      = 8'd2;
    my_pos     = 7'd0;
    step_total = 3'd1;
    errors     = 0;
  endfunction

  function void set_reg(logic [alsched_pkg::CFG_ADDR_W-1:0] idx, logic [7:0] value);
    case (idx)
      alsched_pkg::REG_RANK_COUNT: ranks = value;
      alsched_pkg::REG_MY_INDEX:   my_pos = value[6:0];
      alsched_pkg::REG_STEP_COUNT: step_total = value[2:0];
      default: ;
    endcase
  endfunction

  function int unsigned pending();
    return plan_q.size();
  endfunction

  // Appends one expected result at the tail of the plan.
  function void add_plan(slice_rec_t rec);
    plan_q.insert(plan_q.size(), rec);
  endfunction

  // Expands one accepted step request into its list of slice results.
  function void note_request(logic [2:0] step);
    int unsigned r, idx, delta, dm, d2m, from_i, to_i, n, tx, rx;
    slice_rec_t rec;
    rec = '0;
    if (step >= step_total) begin
      rec.last = 1'b1;
      rec.bad  = 1'b1;
      add_plan(rec);
      return;
    end
    r = ranks;
    if (r < 2) r = 2;
    if (r > 128) r = 128;
    idx    = my_pos % r;
    delta  = 1 << (int'(step_total) - 1 - int'(step));
    dm     = delta % r;
    d2m    = (2 * delta) % r;
    from_i = (idx + r - dm) % r;
    to_i   = (idx + dm) % r;
    n      = (r - 1 + delta) / (2 * delta);
    if (n > alsched_pkg::RESULT_CAP) n = alsched_pkg::RESULT_CAP;
    rec.data.from_index = 7'(from_i);
    rec.data.to_index   = 7'(to_i);
    if (n == 0) begin
      // Distance at or beyond the rank count: one empty result with peers.
      rec.last = 1'b1;
      add_plan(rec);
      return;
    end
    rec.data.slice_count = 7'(n);
    tx = idx;
    rx = from_i;
    for (int unsigned i = 0; i < n; i++) begin
      rec.data.slice_pos = 6'(i);
      rec.data.tx_slice  = 7'(tx);
      rec.data.rx_slice  = 7'(rx);
      rec.last = (i + 1 == n);
      add_plan(rec);
      tx = (tx + r - d2m) % r;
      rx = (rx + r - d2m) % r;
    end
  endfunction

  function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_result(alsched_pkg::out_data_t got, logic got_last, logic got_bad);
    slice_rec_t want;
    if (plan_q.size() == 0) begin
      $display("%0t: unexpected result expected none got tdata %h last %b bad_step %b",
               $time, got, got_last, got_bad);
      errors++;
      return;
    end
    want = plan_q.pop_front();
    cmp_field("from_index",  8'(want.data.from_index),  8'(got.from_index));
    cmp_field("to_index",    8'(want.data.to_index),    8'(got.to_index));
    cmp_field("slice_count", 8'(want.data.slice_count), 8'(got.slice_count));
    cmp_field("slice_pos",   8'(want.data.slice_pos),   8'(got.slice_pos));
    cmp_field("tx_slice",    8'(want.data.tx_slice),    8'(got.tx_slice));
    cmp_field("rx_slice",    8'(want.data.rx_slice),    8'(got.rx_slice));
    cmp_field("zero fill",   8'(want.data.pad),         8'(got.pad));
    cmp_field("last",        8'(want.last),             8'(got_last));
    cmp_field("bad_step",    8'(want.bad),              8'(got_bad));
  endfunction

endclass

module allgather_step_schedule_tb;

  localparam int unsigned QUIET_LIMIT = 1000;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  // in_tdata: step[2:0], zero fill [7:3]
  logic [alsched_pkg::IN_DATA_W-1:0]    in_tdata = '0;
  logic                                 in_tvalid = 1'b0;
  logic                                 in_tready;
  // out_tdata: from_index, to_index, slice_count, slice_pos, tx_slice,
  // rx_slice, zero fill, from the lowest bit up
  logic [alsched_pkg::OUT_DATA_W-1:0]   out_tdata;
  // out_tuser: bad_step
  logic                                 out_tuser;
  logic                                 out_tlast;
  logic                                 out_tvalid;
  logic                                 out_tready = 1'b0;
  logic                                 cfg_we = 1'b0;
  logic [alsched_pkg::CFG_ADDR_W-1:0]   cfg_addr = '0;
  logic [alsched_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;

  slice_plan_board sb = new();
  bit idle_on = 1'b1;

  always #5 clk = ~clk;

  allgather_step_schedule dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Stops sending and waits until every expected result has been taken.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_config(input logic [7:0] rc, input logic [7:0] mi,
                              input logic [7:0] sc);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= alsched_pkg::REG_RANK_COUNT;
    cfg_wdata <= rc;
    @(posedge clk);
    sb.set_reg(alsched_pkg::REG_RANK_COUNT, rc);
    cfg_addr  <= alsched_pkg::REG_MY_INDEX;
    cfg_wdata <= mi;
    @(posedge clk);
    sb.set_reg(alsched_pkg::REG_MY_INDEX, mi);
    cfg_addr  <= alsched_pkg::REG_STEP_COUNT;
    cfg_wdata <= sc;
    @(posedge clk);
    sb.set_reg(alsched_pkg::REG_STEP_COUNT, sc);
    cfg_we <= 1'b0;
  endtask

  // Handshake signals are looked at on the falling edge, where they are stable
  // until the rising edge that takes the request.
  task automatic send_step(input logic [2:0] st);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, st};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    sb.note_request(st);
    @(posedge clk);
  endtask

  initial begin : result_sink
    int unsigned stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = idle_on ? $urandom_range(0, 19) : 0;
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(negedge clk);
      while (!out_tvalid) @(negedge clk);
      sb.check_result(alsched_pkg::out_data_t'(out_tdata), out_tlast, out_tuser);
      @(posedge clk);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(negedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] rc, mi, sc;
    int unsigned eff;
    logic [2:0] st;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Values after reset: two ranks, one step.
    send_step(3'd0);
    send_step(3'd7);

    // Largest ring, last rank, all seven steps and one step past the end.
    write_config(8'd128, 8'd127, 8'd7);
    for (int s = 0; s < 8; s++) send_step(3'(s));

    // Two ranks with seven steps: early steps have no slices to move.
    idle_on = 1'b0;
    write_config(8'd2, 8'd0, 8'd7);
    send_step(3'd0);
    send_step(3'd6);

    // Rank counts outside 2..128 are clamped; my_index is reduced.
    idle_on = 1'b1;
    write_config(8'd255, 8'd100, 8'd7);
    send_step(3'd6);
    send_step(3'd3);
    write_config(8'd0, 8'd127, 8'd1);
    send_step(3'd0);
    send_step(3'd1);
    write_config(8'd129, 8'd200, 8'd3);
    send_step(3'd2);
    send_step(3'd0);
    write_config(8'd1, 8'd1, 8'd2);
    send_step(3'd0);
    send_step(3'd1);

    // A zero step count turns every request into a bad step.
    write_config(8'd100, 8'd99, 8'd0);
    send_step(3'd0);
    send_step(3'd5);

    for (int p = 0; p < 8; p++) begin
      if ($urandom_range(0, 7) == 0) rc = 8'($urandom_range(0, 255));
      else rc = 8'($urandom_range(2, 128));
      mi  = 8'($urandom_range(0, 255));
      eff = (rc < 2) ? 2 : (rc > 128) ? 128 : rc;
      if ($urandom_range(0, 3) == 0) sc = 8'($urandom_range(0, 7));
      else sc = ($clog2(eff) < 1) ? 8'd1 : 8'($clog2(eff));
      idle_on = ($urandom_range(0, 3) != 0);
      write_config(rc, mi, sc);
      repeat ($urandom_range(6, 14)) begin
        if (sc != 0 && $urandom_range(0, 6) != 0) st = 3'($urandom_range(0, sc - 1));
        else st = 3'($urandom_range(0, 7));
        send_step(st);
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
